// File: hw/rtl/bat_pkg.sv
package bat_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_RESOLVE,
    ST_MOVE,
    ST_DONE
  } state_e;

  localparam int unsigned AddrWidth  = 64;
  localparam int unsigned CountWidth = 5;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_idx;
    logic inc_idx;
    logic set_hit;
    logic append;
    logic rd_last;
    logic move;
    logic out_load;
    logic out_success;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  scan_end;
    logic  match;
    logic  found;
    logic  full;
    logic  out_free;
  } status_t;

endpackage

// File: hw/rtl/bat_ctrl.sv
module bat_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bat_pkg::status_t status_i,
  output bat_pkg::cmd_t    cmd_o
);

  bat_pkg::state_e state_q, state_d;
  logic success_q, success_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bat_pkg::ST_IDLE;
      success_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      success_q <= success_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    success_d  = success_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_success = success_q;
    case (state_q)
      bat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          success_d  = 1'b0;
          state_d    = bat_pkg::ST_CHECK;
        end
      end
      bat_pkg::ST_CHECK: begin
        if (status_i.scan_end) begin
          state_d = bat_pkg::ST_RESOLVE;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = bat_pkg::ST_CMP;
        end
      end
      bat_pkg::ST_CMP: begin
        if (status_i.match) begin
          cmd_o.set_hit = 1'b1;
          state_d       = bat_pkg::ST_RESOLVE;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = bat_pkg::ST_CHECK;
        end
      end
      bat_pkg::ST_RESOLVE: begin
        state_d = bat_pkg::ST_DONE;
        case (status_i.kind)
          bat_pkg::KIND_ADD: begin
            if (status_i.found) begin
              success_d = 1'b1;
            end else if (!status_i.full) begin
              cmd_o.append = 1'b1;
              success_d    = 1'b1;
            end
          end
          bat_pkg::KIND_REMOVE: begin
            if (status_i.found) begin
              cmd_o.rd_last = 1'b1;
              state_d       = bat_pkg::ST_MOVE;
            end
          end
          bat_pkg::KIND_LOOKUP: begin
            success_d = status_i.found;
          end
          default: begin
            success_d = 1'b0;
          end
        endcase
      end
      bat_pkg::ST_MOVE: begin
        // last entry data is in the read register now
        cmd_o.move = 1'b1;
        success_d  = 1'b1;
        state_d    = bat_pkg::ST_DONE;
      end
      bat_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/bat_datapath.sv
module bat_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          kind_i,
  input  logic [bat_pkg::AddrWidth-1:0]       address_i,
  input  bat_pkg::cmd_t                       cmd_i,
  output bat_pkg::status_t                    status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_success_o,
  output logic [bat_pkg::CountWidth-1:0]      out_count_o
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [bat_pkg::AddrWidth-1:0] mem [TABLE_ENTRIES];

  bat_pkg::kind_e                kind_q;
  logic [bat_pkg::AddrWidth-1:0] addr_q;
  logic [bat_pkg::AddrWidth-1:0] rdata_q;
  logic [CW-1:0]                 idx_q;
  logic [CW-1:0]                 count_q;
  logic [AW-1:0]                 hit_q;
  logic                          found_q;
  logic                          out_valid_q;
  logic                          out_success_q;
  logic [bat_pkg::CountWidth-1:0] out_count_q;

  logic [CW-1:0]                       last_cnt;
  logic [CW+bat_pkg::CountWidth-1:0]   count_ext;

  assign last_cnt  = count_q - {{(CW-1){1'b0}}, 1'b1};
  assign count_ext = {{bat_pkg::CountWidth{1'b0}}, count_q};

  assign status_o.kind     = kind_q;
  assign status_o.scan_end = (idx_q == count_q);
  assign status_o.match    = (rdata_q == addr_q);
  assign status_o.found    = found_q;
  assign status_o.full     = (count_q == CW'(TABLE_ENTRIES));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_success_o = out_success_q;
  assign out_count_o   = out_count_q;

  // request payload, scan, table write and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= bat_pkg::kind_e'(kind_i);
      addr_q <= address_i;
    end
    if (cmd_i.set_hit) begin
      hit_q <= idx_q[AW-1:0];
    end
    if (cmd_i.rd_idx) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end else if (cmd_i.rd_last) begin
      rdata_q <= mem[last_cnt[AW-1:0]];
    end
    if (cmd_i.append) begin
      mem[count_q[AW-1:0]] <= addr_q;
    end else if (cmd_i.move) begin
      mem[hit_q] <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_success_q <= cmd_i.out_success;
      out_count_q   <= count_ext[bat_pkg::CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + {{(CW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.set_hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.append) begin
        count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
      end else if (cmd_i.move) begin
        count_q <= last_cnt;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("fill count above table size");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (count_q != CW'(TABLE_ENTRIES)))
    else $error("append into full table");

  a_move_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> (found_q && (count_q != '0)))
    else $error("move without a matching entry");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending result");

endmodule

// File: hw/rtl/breakpoint_address_table_unit.sv
// channel   dir  signals                    contents
// s_axis    in   tvalid tready tdata tuser  tdata address, tuser kind
// m_axis    out  tvalid tready tdata        tdata success, entries_in_use
//
// a request scans the table from entry 0 up to the fill count, stopping at the first
// match, and then resolves; a remove that hits adds a move step that copies the last
// entry into the matched slot
// the scan reads one table entry at a time through the single read port
// reset clears the fill count but not the entries; entries at or above the count are never read
// a stalled result is held in the output register; the next request is taken
// meanwhile and waits at its end until the output register is free
module breakpoint_address_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] address
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] success, [5:1] entries_in_use, [7:6] zero
);

  bat_pkg::cmd_t    cmd;
  bat_pkg::status_t status;
  logic             out_success;
  logic [bat_pkg::CountWidth-1:0] out_count;

  bat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bat_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (s_axis_tuser),
    .address_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_success_o (out_success),
    .out_count_o   (out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_success};

endmodule
